>>> src/ulrb_pkg.sv
`timescale 1ns / 1ps
package ulrb_pkg;

    localparam int LINE_COUNT = 8;
    localparam int LINE_BYTES = 64;

    localparam int SLOT_W   = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
    localparam int FILL_W   = $clog2(LINE_BYTES);
    localparam int ADDR_W   = $clog2(LINE_COUNT * LINE_BYTES);
    localparam int STORE_DEPTH = LINE_COUNT * LINE_BYTES;

    localparam int INDEX_W  = 6;
    localparam int LENGTH_W = 6;
    localparam int BYTE_W   = 8;
    // compare width that holds the read index, a length and LINE_BYTES
    localparam int CMP_W    = ((FILL_W > INDEX_W) ? FILL_W : INDEX_W) + 1;

    localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

    typedef enum logic [1:0] {
        OP_RX   = 2'd0,
        OP_POP  = 2'd1,
        OP_READ = 2'd2
    } op_t;

endpackage

>>> src/ulrb_ram.sv
`timescale 1ns / 1ps
module ulrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         q
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            q <= mem[addr];
        end
    end

endmodule

>>> src/uart_line_ring_buffer.sv
`timescale 1ns / 1ps
// The result of an item is strobed on done in the cycle after start is taken.
// Throughput: one item per cycle; busy stays low, the line store serves one
//   access (write of a byte or read of a byte) per cycle on its single port.
// Reset (rst_n, async, active low) clears the slot pointers, fill index and
//   result strobe; line bytes and slot lengths hold garbage until written.
// The receiver cannot stall: each result shows for exactly one cycle.
module uart_line_ring_buffer
    import ulrb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          op,
    input  logic [BYTE_W-1:0]   rx_byte,
    input  logic [INDEX_W-1:0]  read_index,
    output logic                done,
    output logic                line_available,
    output logic [LENGTH_W-1:0] line_length,
    output logic [BYTE_W-1:0]   read_byte,
    output logic                popped
);

    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0] read_slot_reg, read_slot_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] slot_len_reg [LINE_COUNT];

    logic                done_reg;
    logic                avail_reg;
    logic [LENGTH_W-1:0] len_reg;
    logic                popped_reg, popped_next;
    logic                rd_hit_reg, rd_hit_next;

    logic              accept;
    logic              avail;
    logic [FILL_W-1:0] len_cur;
    logic [CMP_W-1:0]  len_ext;
    logic [CMP_W-1:0]  idx_ext;
    logic              len_we;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] ram_q;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign avail   = (read_slot_reg != write_slot_reg);
    assign len_cur = avail ? slot_len_reg[read_slot_reg] : '0;
    assign len_ext = CMP_W'(len_cur);
    assign idx_ext = CMP_W'(read_index);

    assign wr_addr = ADDR_W'(write_slot_reg) * ADDR_W'(LINE_BYTES) + ADDR_W'(fill_reg);
    assign rd_addr = ADDR_W'(read_slot_reg) * ADDR_W'(LINE_BYTES)
                   + ADDR_W'(idx_ext[FILL_W-1:0]);
    assign ram_addr = ram_we ? wr_addr : rd_addr;

    always_comb
    begin
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        fill_next       = fill_reg;
        len_we          = 1'b0;
        ram_we          = 1'b0;
        popped_next     = 1'b0;
        rd_hit_next     = 1'b0;
        if (accept)
        begin
            case (op_t'(op))
                OP_RX:
                begin
                    if (rx_byte < SPACE_CHAR)
                    begin
                        // control char closes the line
                        len_we    = 1'b1;
                        fill_next = '0;
                        if (write_slot_reg == SLOT_W'(LINE_COUNT - 1))
                            write_slot_next = '0;
                        else
                            write_slot_next = write_slot_reg + 1'b1;
                    end
                    else if (fill_reg != FILL_W'(LINE_BYTES - 1))
                    begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (avail)
                    begin
                        popped_next = 1'b1;
                        if (read_slot_reg == SLOT_W'(LINE_COUNT - 1))
                            read_slot_next = '0;
                        else
                            read_slot_next = read_slot_reg + 1'b1;
                    end
                end
                OP_READ:
                begin
                    rd_hit_next = avail && (idx_ext < len_ext)
                               && (idx_ext < CMP_W'(LINE_BYTES));
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            fill_reg       <= '0;
            done_reg       <= 1'b0;
            popped_reg     <= 1'b0;
            rd_hit_reg     <= 1'b0;
        end
        else
        begin
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
            fill_reg       <= fill_next;
            done_reg       <= accept;
            popped_reg     <= popped_next;
            rd_hit_reg     <= rd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            avail_reg <= avail;
            len_reg   <= LENGTH_W'(len_ext);
        end
        if (len_we)
        begin
            slot_len_reg[write_slot_reg] <= fill_reg;
        end
    end

    ulrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (rx_byte),
        .q     (ram_q)
    );

    assign done           = done_reg;
    assign line_available = avail_reg;
    assign line_length    = len_reg;
    assign popped         = popped_reg;
    assign read_byte      = rd_hit_reg ? ram_q : '0;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("missing result strobe after accepted item");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept))
        else $error("result strobe without an accepted item");

    a_pop_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
        (done && popped) |-> line_available)
        else $error("pop reported on an empty ring");

    a_read_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (done && read_byte != '0) |-> (line_available && $past(op) == OP_READ))
        else $error("nonzero read byte without a read of a waiting line");

    a_empty_length: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !line_available) |-> (line_length == '0))
        else $error("nonzero length reported with no line waiting");

endmodule
